// ===== rtl/tmw_pkg.sv =====
`timescale 1ns / 1ps

package tmw_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;

    localparam int ADDR_W  = $clog2(MAX_WINDOW);
    localparam int COUNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = SAMPLE_BITS + ADDR_W;
    localparam int QUOT_W  = SUM_W + 1;
    localparam int STEP_W  = $clog2(SUM_W + 1);

    localparam int WINDOW_W = 7;
    localparam int SKIP_W   = 6;
    localparam int KEEP_W   = 7;
    localparam int OFFSET_W = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_LOW      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_COUNT    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESULT_OFFSET = 2'd3;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 7'd20;
    localparam logic [SKIP_W-1:0]   SKIP_RESET   = 6'd4;
    localparam logic [KEEP_W-1:0]   KEEP_RESET   = 7'd12;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd0;

    localparam logic [WINDOW_W-1:0] WINDOW_MIN = 7'd2;

endpackage

// ===== rtl/tmw_divider.sv =====
`timescale 1ns / 1ps

module tmw_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [tmw_pkg::SUM_W-1:0]  dividend,
    input  logic        [tmw_pkg::KEEP_W-1:0] divisor,
    output logic                              done,
    output logic signed [tmw_pkg::QUOT_W-1:0] quotient
);

    import tmw_pkg::*;

    logic                     busy_reg;
    logic                     done_reg;
    logic                     neg_reg;
    logic [KEEP_W-1:0]        rem_reg;
    logic [SUM_W-1:0]         mag_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [QUOT_W-1:0] quot_reg;

    logic [KEEP_W:0]   trial;
    logic [KEEP_W:0]   diff;
    logic              fits;
    logic [KEEP_W-1:0] rem_next;
    logic [SUM_W-1:0]  mag_next;
    logic [QUOT_W-1:0] mag_wide;

    assign trial    = {rem_reg, mag_reg[SUM_W-1]};
    assign diff     = trial - {1'b0, divisor};
    assign fits     = trial >= {1'b0, divisor};
    assign rem_next = fits ? diff[KEEP_W-1:0] : trial[KEEP_W-1:0];
    assign mag_next = {mag_reg[SUM_W-2:0], fits};
    assign mag_wide = {1'b0, mag_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            rem_reg  <= '0;
            mag_reg  <= '0;
            step_reg <= '0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (step_reg == STEP_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                neg_reg  <= dividend[SUM_W-1];
                mag_reg  <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
                rem_reg  <= '0;
                step_reg <= STEP_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                rem_reg  <= rem_next;
                mag_reg  <= mag_next;
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    quot_reg <= neg_reg ? $signed(~mag_wide + 1'b1) : $signed(mag_wide);
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ===== rtl/trimmed_mean_window.sv =====
`timescale 1ns / 1ps

// Trimmed mean over a window of signed Q8.8 samples. Each accepted sample is
// placed in order in a 64-entry store with one write and one read port by
// walking down from the top entry one compare-and-shift a cycle; a sample
// that opens a window is written straight in, and otherwise the walk moves
// from no entry up to 63 entries before in_ready returns. The sample that
// closes the window then sums the kept entries over the same read port,
// starts the restoring divider, which takes one quotient bit a cycle, and
// saturates and registers the result. The result waits in an output
// register, so a stalled consumer holds up nothing until the next window
// closes. Configuration is taken at once on cfg_write and should change
// only while the block is idle.

module trimmed_mean_window (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [tmw_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tmw_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [tmw_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [tmw_pkg::SAMPLE_BITS-1:0] trimmed_mean
);

    import tmw_pkg::*;

    localparam int RES_W = QUOT_W + 1;
    localparam logic signed [RES_W-1:0] RES_MAX = RES_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RES_W-1:0] RES_MIN = -RES_MAX - RES_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_LAST,
        S_CHECK,
        S_SUM,
        S_DIV_START,
        S_DIV_WAIT,
        S_DONE
    } state_t;

    logic [SAMPLE_BITS-1:0] store_mem [MAX_WINDOW];

    state_t                  state_reg,  state_next;
    logic [WINDOW_W-1:0]     window_reg;
    logic [SKIP_W-1:0]       skip_reg;
    logic [KEEP_W-1:0]       keep_reg;
    logic [OFFSET_W-1:0]     offset_reg;
    logic [COUNT_W-1:0]      fill_reg,   fill_next;
    logic [ADDR_W-1:0]       pos_reg,    pos_next;
    logic [SAMPLE_BITS-1:0]  value_reg,  value_next;
    logic [COUNT_W-1:0]      idx_reg,    idx_next;
    logic [COUNT_W-1:0]      end_reg,    end_next;
    logic                    acc_vld_reg, acc_vld_next;
    logic signed [SUM_W-1:0] sum_reg,    sum_next;
    logic [SAMPLE_BITS-1:0]  mean_reg,   mean_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]  out_data_reg,  out_data_next;
    logic [SAMPLE_BITS-1:0]  rdata_reg;

    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [SAMPLE_BITS-1:0]   mem_wdata;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     div_start;
    logic                     div_done;
    logic signed [QUOT_W-1:0] div_quot;

    logic [KEEP_W-1:0]      keep_eff;
    logic [COUNT_W-1:0]     window_eff;
    logic [COUNT_W-1:0]     count;
    logic [KEEP_W:0]        span_end;
    logic signed [RES_W-1:0] res;

    assign keep_eff = (keep_reg == '0) ? KEEP_W'(1) : keep_reg;

    always_comb
    begin
        if (window_reg < WINDOW_MIN)
            window_eff = COUNT_W'(WINDOW_MIN);
        else if (32'(window_reg) > MAX_WINDOW)
            window_eff = COUNT_W'(MAX_WINDOW);
        else
            window_eff = COUNT_W'(window_reg);
    end

    assign count    = fill_reg + 1'b1;
    assign span_end = (KEEP_W + 1)'(skip_reg) + (KEEP_W + 1)'(keep_eff);
    assign res      = RES_W'(div_quot) + RES_W'($signed(offset_reg));

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign trimmed_mean = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        value_next     = value_reg;
        idx_next       = idx_reg;
        end_next       = end_reg;
        acc_vld_next   = acc_vld_reg;
        sum_next       = sum_reg;
        mean_next      = mean_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = value_reg;
        rd_addr        = '0;
        div_start      = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    value_next = sample;
                    pos_next   = fill_reg[ADDR_W-1:0];
                    if (fill_reg == '0)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        mem_wdata  = sample;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        rd_addr    = fill_reg[ADDR_W-1:0] - 1'b1;
                        state_next = S_INS_CMP;
                    end
                end
            end
            S_INS_CMP:
            begin
                mem_we = 1'b1;
                if ($signed(rdata_reg) > $signed(value_reg))
                begin
                    // shift the larger entry up one place
                    mem_wdata = rdata_reg;
                    pos_next  = pos_reg - 1'b1;
                    if (pos_reg == ADDR_W'(1))
                        state_next = S_INS_LAST;
                    else
                        rd_addr = pos_reg - ADDR_W'(2);
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_INS_LAST:
            begin
                mem_we     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (count >= window_eff)
                begin
                    fill_next    = '0;
                    idx_next     = COUNT_W'(skip_reg);
                    end_next     = (span_end < (KEEP_W + 1)'(count)) ? COUNT_W'(span_end) : count;
                    acc_vld_next = 1'b0;
                    sum_next     = '0;
                    state_next   = S_SUM;
                end
                else
                begin
                    fill_next  = count;
                    state_next = S_IDLE;
                end
            end
            S_SUM:
            begin
                if (acc_vld_reg)
                    sum_next = sum_reg + SUM_W'($signed(rdata_reg));
                if (idx_reg < end_reg)
                begin
                    rd_addr      = idx_reg[ADDR_W-1:0];
                    idx_next     = idx_reg + 1'b1;
                    acc_vld_next = 1'b1;
                end
                else
                begin
                    acc_vld_next = 1'b0;
                    if (!acc_vld_reg)
                        state_next = S_DIV_START;
                end
            end
            S_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (res > RES_MAX)
                        mean_next = RES_MAX[SAMPLE_BITS-1:0];
                    else if (res < RES_MIN)
                        mean_next = RES_MIN[SAMPLE_BITS-1:0];
                    else
                        mean_next = res[SAMPLE_BITS-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = mean_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= mem_wdata;
        rdata_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= WINDOW_RESET;
            skip_reg      <= SKIP_RESET;
            keep_reg      <= KEEP_RESET;
            offset_reg    <= OFFSET_RESET;
            fill_reg      <= '0;
            pos_reg       <= '0;
            value_reg     <= '0;
            idx_reg       <= '0;
            end_reg       <= '0;
            acc_vld_reg   <= 1'b0;
            sum_reg       <= '0;
            mean_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            value_reg     <= value_next;
            idx_reg       <= idx_next;
            end_reg       <= end_next;
            acc_vld_reg   <= acc_vld_next;
            sum_reg       <= sum_next;
            mean_reg      <= mean_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_WINDOW_LENGTH: window_reg <= cfg_data[WINDOW_W-1:0];
                    CFG_SKIP_LOW:      skip_reg   <= cfg_data[SKIP_W-1:0];
                    CFG_KEEP_COUNT:    keep_reg   <= cfg_data[KEEP_W-1:0];
                    CFG_RESULT_OFFSET: offset_reg <= cfg_data[OFFSET_W-1:0];
                    default:           window_reg <= window_reg;
                endcase
            end
        end
    end

    tmw_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (keep_eff),
        .done     (div_done),
        .quotient (div_quot)
    );

endmodule

// ===== tb/tmw_mean_checker.sv =====
`timescale 1ns / 1ps

module tmw_mean_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [tmw_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [tmw_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic signed [tmw_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic signed [tmw_pkg::SAMPLE_BITS-1:0] trimmed_mean,
    output int                                     fail_count,
    output int                                     means_waiting,
    output int                                     means_checked
);

    import tmw_pkg::*;

    localparam longint MEAN_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint MEAN_MIN = -MEAN_MAX - 1;

    logic [WINDOW_W-1:0]           window_reg;
    logic [SKIP_W-1:0]             skip_reg;
    logic [KEEP_W-1:0]             keep_reg;
    logic signed [OFFSET_W-1:0]    offset_reg;
    logic signed [SAMPLE_BITS-1:0] ordered [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] expected_means [$];
    int                            held;
    int                            errors = 0;
    int                            checked = 0;

    always @(posedge clk or negedge rst_n)
    begin : watch
        int                            pos;
        int                            span;
        int                            keep_n;
        int                            i;
        longint                        total;
        longint                        mean;
        logic signed [SAMPLE_BITS-1:0] want;

        if (!rst_n)
        begin
            window_reg = WINDOW_RESET;
            skip_reg   = SKIP_RESET;
            keep_reg   = KEEP_RESET;
            offset_reg = OFFSET_RESET;
            held       = 0;
            errors     = 0;
            checked    = 0;
            expected_means.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_WINDOW_LENGTH: window_reg = cfg_data[WINDOW_W-1:0];
                    CFG_SKIP_LOW:      skip_reg   = cfg_data[SKIP_W-1:0];
                    CFG_KEEP_COUNT:    keep_reg   = cfg_data[KEEP_W-1:0];
                    CFG_RESULT_OFFSET: offset_reg = cfg_data[OFFSET_W-1:0];
                    default:           ;
                endcase
            end

            // compare the result transfer before this edge's sample can add to the queue
            if (out_valid && out_ready)
            begin
                if (expected_means.size() == 0)
                begin
                    errors++;
                    $error("trimmed_mean %0d arrived with no window closed", trimmed_mean);
                end
                else
                begin
                    want = expected_means.pop_front();
                    checked++;
                    if (trimmed_mean !== want)
                    begin
                        errors++;
                        $error("trimmed_mean mismatch: expected %0d, actual %0d",
                               want, trimmed_mean);
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                pos = held;
                while (pos > 0 && ordered[pos-1] > sample)
                begin
                    ordered[pos] = ordered[pos-1];
                    pos--;
                end
                ordered[pos] = sample;
                held++;

                span = (window_reg < WINDOW_MIN) ? int'(WINDOW_MIN) :
                       (window_reg > MAX_WINDOW) ? MAX_WINDOW : int'(window_reg);
                if (held >= span)
                begin
                    keep_n = (keep_reg == 0) ? 1 : int'(keep_reg);
                    total  = 0;
                    for (i = int'(skip_reg); i < int'(skip_reg) + keep_n && i < held; i++)
                        total += ordered[i];
                    mean = total / keep_n + offset_reg;
                    if (mean > MEAN_MAX)
                        mean = MEAN_MAX;
                    else if (mean < MEAN_MIN)
                        mean = MEAN_MIN;
                    expected_means.push_back(mean[SAMPLE_BITS-1:0]);
                    held = 0;
                end
            end
        end

        fail_count    <= errors;
        means_waiting <= expected_means.size();
        means_checked <= checked;
    end

endmodule

// ===== tb/tb_trimmed_mean_window.sv =====
`timescale 1ns / 1ps

module tb_trimmed_mean_window;

    import tmw_pkg::*;

    localparam int SAMPLE_MAX    = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int SAMPLE_MIN    = -SAMPLE_MAX - 1;
    localparam int SAMPLE_TARGET = 450;
    localparam int SETTLE_CYCLES = 200;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    logic [CFG_INDEX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [SAMPLE_BITS-1:0] trimmed_mean;

    int fail_count;
    int means_waiting;
    int means_checked;
    int cycles;
    int samples_sent  = 0;
    int settings_used = 0;
    bit steady;

    trimmed_mean_window DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .trimmed_mean (trimmed_mean)
    );

    tmw_mean_checker mean_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .trimmed_mean  (trimmed_mean),
        .fail_count    (fail_count),
        .means_waiting (means_waiting),
        .means_checked (means_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // drop ready for a random stall before each result, then hold it until the transfer
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic write_settings(input int w, input int s, input int k, input int o);
        cfg_write <= 1'b1;
        cfg_index <= CFG_WINDOW_LENGTH;
        cfg_data  <= CFG_DATA_W'(w[WINDOW_W-1:0]);
        @(posedge clk);
        cfg_index <= CFG_SKIP_LOW;
        cfg_data  <= CFG_DATA_W'(s[SKIP_W-1:0]);
        @(posedge clk);
        cfg_index <= CFG_KEEP_COUNT;
        cfg_data  <= CFG_DATA_W'(k[KEEP_W-1:0]);
        @(posedge clk);
        cfg_index <= CFG_RESULT_OFFSET;
        cfg_data  <= CFG_DATA_W'(o[OFFSET_W-1:0]);
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // hold the sample until the transfer
    task automatic send_sample(input int v);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= v[SAMPLE_BITS-1:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        samples_sent++;
    endtask

    task automatic settle();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (means_waiting != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int n);
        int style;
        int anchor;
        int spread;
        int k;
        int val;
        style  = $urandom_range(0, 4);
        anchor = int'($urandom_range(0, 65535)) + SAMPLE_MIN;
        spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 4000);
        steady = ($urandom_range(0, 4) == 0);
        for (k = 0; k < n; k++)
        begin
            case (style)
                0: val = int'($urandom_range(0, 65535)) + SAMPLE_MIN;
                1: val = anchor + int'($urandom_range(0, 2 * spread)) - spread;
                2:
                begin
                    case ($urandom_range(0, 5))
                        0:       val = SAMPLE_MAX;
                        1:       val = SAMPLE_MIN;
                        2:       val = 0;
                        3:       val = -1;
                        4:       val = 1;
                        default: val = int'($urandom_range(0, 65535)) + SAMPLE_MIN;
                    endcase
                end
                3:       val = anchor - k * spread;
                default: val = anchor + k * spread;
            endcase
            if (val > SAMPLE_MAX)
                val = SAMPLE_MAX;
            else if (val < SAMPLE_MIN)
                val = SAMPLE_MIN;
            send_sample(val);
        end
    endtask

    initial
    begin
        int round;
        int first_random;
        int span;
        int windows;
        int n;
        int w;
        int s;
        int k;
        int o;

        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_WINDOW_LENGTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        sample    = '0;
        steady    = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window below the minimum, full-scale pairs and rounding of an odd sum
        write_settings(0, 0, 2, 0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        settle();

        // zero keep count, saturation at both bounds
        write_settings(1, 0, 0, SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        settle();
        write_settings(2, 1, 1, SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        settle();

        // skip covers every entry: offset alone
        write_settings(3, 63, 64, 32'sh1234);
        send_sample(100);
        send_sample(-100);
        send_sample(7);
        settle();

        // negative quotient truncates toward zero
        write_settings(3, 0, 2, 0);
        send_sample(-1);
        send_sample(-2);
        send_sample(5);
        settle();

        // shrink the window below the entries already held
        write_settings(5, 1, 3, -256);
        send_sample(32'sh5555);
        send_sample(-32'sh5556);
        send_sample(1);
        settle();
        write_settings(2, 0, 4, 0);
        send_sample(0);
        settle();

        round        = 0;
        first_random = samples_sent;
        while (samples_sent - first_random < SAMPLE_TARGET)
        begin
            case (round)
                0:
                begin
                    w = WINDOW_RESET;
                    s = SKIP_RESET;
                    k = KEEP_RESET;
                    o = 0;
                end
                1:
                begin
                    w = 40;
                    s = 2;
                    k = 24;
                    o = 0;
                end
                2:
                begin
                    w = 40;
                    s = 2;
                    k = 24;
                    o = 2;
                end
                3:
                begin
                    w = 127;
                    s = 0;
                    k = 64;
                    o = int'($urandom_range(0, 65535)) + SAMPLE_MIN;
                end
                4:
                begin
                    w = MAX_WINDOW;
                    s = 63;
                    k = 1;
                    o = 0;
                end
                5:
                begin
                    w = 2;
                    s = 0;
                    k = 127;
                    o = SAMPLE_MAX;
                end
                default:
                begin
                    w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
                    s = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
                    k = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
                    o = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) + SAMPLE_MIN
                                                    : int'($urandom_range(0, 1024)) - 512;
                end
            endcase
            span    = (w < 2) ? 2 : (w > MAX_WINDOW) ? MAX_WINDOW : w;
            windows = (span > 16) ? 1 : $urandom_range(1, 4);
            n       = span * windows;
            if ($urandom_range(0, 4) == 0)
                n += $urandom_range(1, span - 1);
            write_settings(w, s, k, o);
            run_phase(n);
            settle();
            round++;
        end

        if (means_waiting != 0)
            $error("%0d trimmed means never arrived", means_waiting);
        $display("Sent %0d samples under %0d register settings; %0d trimmed means compared.",
                 samples_sent, settings_used, means_checked);
        if (fail_count == 0 && means_waiting == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
